// ===== hdl/qta_pkg.sv =====
// ----------------------------------------------------------------------------
// qta_pkg: shared types, constants and helpers
// Node word layout of the quadtree store and small helpers used by the
// walk controller, the clearing sweep and the top level.
// ----------------------------------------------------------------------------
package qta_pkg;

	localparam int ROOT_LOG2_DEF = 6;
	localparam int NEED_W        = 7;
	localparam int POS_W         = 6;
	localparam int RSIZE_W       = 7;
	localparam int CODE_W        = 4;
	localparam int CORNERS       = 4;
	localparam int CMP_W         = 16;

	// One node of the tree: taken flag, allocated-below flag and the four
	// free-size codes of its children. Code 0 is no space, code k is 2^(k-1).
	typedef struct packed {
		logic                              taken;
		logic                              alloc_below;
		logic [CORNERS-1:0][CODE_W-1:0]    free_code;
	} node_t;

	// Number of nodes of a complete quadtree with root_log2+1 levels.
	function automatic int quad_node_total(input int root_log2);
		return ((1 << (2 * (root_log2 + 1))) - 1) / 3;
	endfunction

	// True when the free size encoded by code covers need.
	function automatic logic code_fits(input logic [CODE_W-1:0] code,
		input logic [NEED_W-1:0] need);
		logic [CMP_W-1:0] sz;
		sz = (code == '0) ? '0 : (CMP_W'(1) << (code - CODE_W'(1)));
		return sz >= CMP_W'(need);
	endfunction

	// Largest of the four child codes.
	function automatic logic [CODE_W-1:0] max_code(
		input logic [CORNERS-1:0][CODE_W-1:0] codes);
		logic [CODE_W-1:0] a;
		logic [CODE_W-1:0] b;
		a = (codes[0] > codes[1]) ? codes[0] : codes[1];
		b = (codes[2] > codes[3]) ? codes[2] : codes[3];
		return (a > b) ? a : b;
	endfunction

endpackage

// ===== hdl/qta_store.sv =====
// ----------------------------------------------------------------------------
// qta_store: node memory
// Simple dual-port synchronous RAM holding one node word per tree node,
// one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module qta_store
	import qta_pkg::*;
#(
	parameter int DEPTH = quad_node_total(ROOT_LOG2_DEF),
	parameter int AW    = $clog2(quad_node_total(ROOT_LOG2_DEF))
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  node_t         wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output node_t         rd_data
);

	node_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/qta_clear.sv =====
// ----------------------------------------------------------------------------
// qta_clear: reset sweep of the node memory
// After reset, writes every node once in index order with its reset word:
// flags clear and each child code equal to the child's own size.
// ----------------------------------------------------------------------------
module qta_clear
	import qta_pkg::*;
#(
	parameter int ROOT_LOG2 = ROOT_LOG2_DEF,
	parameter int AW        = $clog2(quad_node_total(ROOT_LOG2_DEF))
) (
	input  logic          clk,
	input  logic          arst_n,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output node_t         wr_data,
	output logic          done
);

	localparam int NODES = quad_node_total(ROOT_LOG2);
	localparam int LW    = $clog2(ROOT_LOG2 + 1);
	localparam int CNT_W = 2 * ROOT_LOG2 + 1;

	logic [AW-1:0]    addr_q;
	logic [LW-1:0]    level_q;
	logic [CNT_W-1:0] level_cnt_q;
	logic [CNT_W-1:0] left_q;
	logic             done_q;
	logic [CODE_W-1:0] code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			level_q     <= '0;
			level_cnt_q <= CNT_W'(1);
			left_q      <= CNT_W'(1);
			done_q      <= 1'b0;
		end else if (!done_q) begin
			addr_q <= addr_q + AW'(1);
			if (addr_q == AW'(NODES - 1)) begin
				done_q <= 1'b1;
			end
			if (left_q == CNT_W'(1)) begin
				// Last node of this level: the next level is four times wider.
				level_q     <= level_q + LW'(1);
				level_cnt_q <= level_cnt_q << 2;
				left_q      <= level_cnt_q << 2;
			end else begin
				left_q <= left_q - CNT_W'(1);
			end
		end
	end

	assign code = (level_q < LW'(ROOT_LOG2))
		? (CODE_W'(ROOT_LOG2) - CODE_W'(level_q)) : '0;

	always_comb begin
		wr_data             = '0;
		wr_data.taken       = 1'b0;
		wr_data.alloc_below = 1'b0;
		for (int c = 0; c < CORNERS; c++) begin
			wr_data.free_code[c] = code;
		end
	end

	assign wr_en   = !done_q;
	assign wr_addr = addr_q;
	assign done    = done_q;

endmodule

// ===== hdl/qta_ctrl.sv =====
// ----------------------------------------------------------------------------
// qta_ctrl: walk controller
// Descends the tree one level per cycle reading the node memory, then, when it
// marks a node, climbs back one level per cycle with a read-modify-write of each ancestor.
// ----------------------------------------------------------------------------
module qta_ctrl
	import qta_pkg::*;
#(
	parameter int ROOT_LOG2 = ROOT_LOG2_DEF,
	parameter int AW        = $clog2(quad_node_total(ROOT_LOG2_DEF))
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [NEED_W-1:0]  needed_width,
	input  logic [NEED_W-1:0]  needed_height,
	output logic               busy,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  node_t              rd_data,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output node_t              wr_data,
	output logic               done,
	output logic [POS_W-1:0]   region_x,
	output logic [POS_W-1:0]   region_y,
	output logic [RSIZE_W-1:0] region_size,
	output logic               marked
);

	localparam int LW = $clog2(ROOT_LOG2 + 1);
	localparam int SW = ROOT_LOG2 + 1;
	localparam int PW = ROOT_LOG2;

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_DESCEND = 2'd1;
	localparam logic [1:0] ST_ASCEND  = 2'd2;

	logic [1:0]        state_q;
	logic [AW-1:0]     idx_q;
	logic [LW-1:0]     level_q;
	logic [SW-1:0]     size_q;
	logic [PW-1:0]     px_q;
	logic [PW-1:0]     py_q;
	logic [SW-1:0]     rs_q;
	logic              corner_valid_q;
	logic [NEED_W-1:0] need_q;
	logic [1:0]        corner_q;
	logic [CODE_W-1:0] carry_q;

	logic                done_q;
	logic [POS_W-1:0]    res_x_q;
	logic [POS_W-1:0]    res_y_q;
	logic [RSIZE_W-1:0]  res_size_q;
	logic                res_marked_q;

	logic [SW-1:0]     half;
	logic [SW-1:0]     rs_n;
	logic              can_take;
	logic              desc_ok;
	logic              have_best;
	logic [1:0]        best;
	logic [AW-1:0]     idx_m1;
	logic [AW-1:0]     child_idx;
	logic [PW-1:0]     px_n;
	logic [PW-1:0]     py_n;
	node_t             upd;
	logic [CODE_W-1:0] upd_max;

	assign half     = size_q >> 1;
	assign can_take = !rd_data.alloc_below;
	assign rs_n     = can_take ? size_q : rs_q;
	assign desc_ok  = (level_q < LW'(ROOT_LOG2)) && (CMP_W'(half) >= CMP_W'(need_q));
	assign idx_m1   = idx_q - AW'(1);

	// First child in corner order whose free size covers the request.
	always_comb begin
		have_best = 1'b0;
		best      = 2'd0;
		if (desc_ok) begin
			for (int c = CORNERS - 1; c >= 0; c--) begin
				if (code_fits(rd_data.free_code[c], need_q)) begin
					have_best = 1'b1;
					best      = 2'(c);
				end
			end
		end
	end

	assign child_idx = (idx_q << 2) + AW'(1) + AW'(best);
	assign px_n = (best == 2'd1 || best == 2'd2) ? (px_q + PW'(half)) : px_q;
	assign py_n = best[1] ? (py_q + PW'(half)) : py_q;

	// Ancestor update on the way up: own flag and the child's new code.
	always_comb begin
		upd                      = rd_data;
		upd.alloc_below          = 1'b1;
		upd.free_code[corner_q]  = carry_q;
	end
	assign upd_max = max_code(upd.free_code);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = upd;
		case (state_q)
			ST_IDLE: begin
				rd_en   = accept;
				rd_addr = '0;
			end
			ST_DESCEND: begin
				if (!rd_data.taken) begin
					if (have_best) begin
						rd_en   = 1'b1;
						rd_addr = child_idx;
					end else if (can_take && corner_valid_q) begin
						// Mark the node taken and fetch its parent.
						wr_en         = 1'b1;
						wr_data       = rd_data;
						wr_data.taken = 1'b1;
						rd_en         = 1'b1;
						rd_addr       = idx_m1 >> 2;
					end
				end
			end
			ST_ASCEND: begin
				wr_en = 1'b1;
				if (idx_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = idx_m1 >> 2;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DESCEND;
					end
				end
				ST_DESCEND: begin
					if (rd_data.taken) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (!have_best) begin
						done_q  <= 1'b1;
						state_q <= (can_take && corner_valid_q) ? ST_ASCEND : ST_IDLE;
					end
				end
				ST_ASCEND: begin
					if (idx_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_q          <= '0;
					level_q        <= '0;
					size_q         <= SW'(1) << ROOT_LOG2;
					px_q           <= '0;
					py_q           <= '0;
					rs_q           <= '0;
					corner_valid_q <= 1'b0;
					need_q         <= (needed_width > needed_height)
						? needed_width : needed_height;
				end
			end
			ST_DESCEND: begin
				if (rd_data.taken) begin
					res_x_q      <= POS_W'(px_q);
					res_y_q      <= POS_W'(py_q);
					res_size_q   <= RSIZE_W'(rs_q);
					res_marked_q <= 1'b0;
				end else if (have_best) begin
					idx_q          <= child_idx;
					level_q        <= level_q + LW'(1);
					size_q         <= half;
					px_q           <= px_n;
					py_q           <= py_n;
					rs_q           <= rs_n;
					corner_valid_q <= 1'b1;
				end else begin
					res_x_q      <= POS_W'(px_q);
					res_y_q      <= POS_W'(py_q);
					res_size_q   <= RSIZE_W'(rs_n);
					res_marked_q <= can_take && corner_valid_q;
					idx_q        <= idx_m1 >> 2;
					corner_q     <= idx_m1[1:0];
					carry_q      <= '0;
				end
			end
			ST_ASCEND: begin
				idx_q    <= idx_m1 >> 2;
				corner_q <= idx_m1[1:0];
				carry_q  <= upd_max;
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign region_x    = res_x_q;
	assign region_y    = res_y_q;
	assign region_size = res_size_q;
	assign marked      = res_marked_q;

endmodule

// ===== hdl/quadtree_atlas_region_allocator_top.sv =====
// ----------------------------------------------------------------------------
// quadtree_atlas_region_allocator_top: square region allocator
// Hands out square regions of a square atlas kept as an implicit quadtree.
// ----------------------------------------------------------------------------
// Usage notes.
// A request transaction is accepted at a rising edge where start is high and
// busy is low; needed_width and needed_height are sampled at that edge.
// Exactly one result transaction follows: done is high for one cycle while
// region_x, region_y, region_size and marked hold the answer. The receiver
// cannot stall, so the result is simply presented for that single cycle.
// The walk reads one tree level per cycle from the node memory, descending D
// levels, where D runs from 0 to ROOT_LOG2; done rises when the descent ends.
// When a node is marked, the climb back starts in the cycle in which done is
// high and rewrites one ancestor per cycle, fetching each through the single
// memory read port. A new request is not accepted until the walk, and any
// climb, has ended; the default atlas is 64 on a side. After reset the block
// is busy for one sweep of the node memory, one node per cycle (5461 nodes
// for the default size), which writes every node back to its empty state.
// Requests are held off by busy until the sweep ends.
// ----------------------------------------------------------------------------
module quadtree_atlas_region_allocator_top
	import qta_pkg::*;
#(
	parameter int ROOT_LOG2 = ROOT_LOG2_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [NEED_W-1:0]  needed_width,
	input  logic [NEED_W-1:0]  needed_height,
	output logic               done,
	output logic [POS_W-1:0]   region_x,
	output logic [POS_W-1:0]   region_y,
	output logic [RSIZE_W-1:0] region_size,
	output logic               marked
);

	localparam int NODES = quad_node_total(ROOT_LOG2);
	localparam int AW    = $clog2(NODES);

	// Clearing sweep write port.
	logic          clr_we;
	logic [AW-1:0] clr_addr;
	node_t         clr_data;
	logic          clr_done;

	// Walk controller memory ports.
	logic          ctl_busy;
	logic          ctl_re;
	logic [AW-1:0] ctl_raddr;
	node_t         ctl_rdata;
	logic          ctl_we;
	logic [AW-1:0] ctl_waddr;
	node_t         ctl_wdata;

	// Shared memory write port: the sweep owns it until it finishes, the
	// controller afterwards. The two never write in the same cycle.
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	node_t         mem_wdata;

	logic accept;

	assign busy   = !clr_done || ctl_busy;
	assign accept = start && !busy;

	assign mem_we    = clr_we || ctl_we;
	assign mem_waddr = clr_done ? ctl_waddr : clr_addr;
	assign mem_wdata = clr_done ? ctl_wdata : clr_data;

	qta_clear #(
		.ROOT_LOG2 (ROOT_LOG2),
		.AW        (AW)
	) u_clear (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (clr_we),
		.wr_addr (clr_addr),
		.wr_data (clr_data),
		.done    (clr_done)
	);

	qta_store #(
		.DEPTH (NODES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (ctl_re),
		.rd_addr (ctl_raddr),
		.rd_data (ctl_rdata)
	);

	qta_ctrl #(
		.ROOT_LOG2 (ROOT_LOG2),
		.AW        (AW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.needed_width  (needed_width),
		.needed_height (needed_height),
		.busy          (ctl_busy),
		.rd_en         (ctl_re),
		.rd_addr       (ctl_raddr),
		.rd_data       (ctl_rdata),
		.wr_en         (ctl_we),
		.wr_addr       (ctl_waddr),
		.wr_data       (ctl_wdata),
		.done          (done),
		.region_x      (region_x),
		.region_y      (region_y),
		.region_size   (region_size),
		.marked        (marked)
	);

endmodule
